// ===== design/sstc_pkg.sv =====
// Shared types, codes and constants of the scheduled stepper turn controller.
`timescale 1ns / 1ps

package sstc_pkg;

  localparam logic [16:0] WINDOW_SECONDS = 17'd79200;
  localparam logic [8:0]  DEG_FULL       = 9'd360;
  localparam logic [4:0]  TPD_MIN        = 5'd1;
  localparam logic [4:0]  TPD_MAX        = 5'd24;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_MANUAL  = 2'd1;
  localparam logic [1:0] ACT_PRELOAD = 2'd2;

  localparam logic [1:0] REG_ENABLE     = 2'd0;
  localparam logic [1:0] REG_DEGREES    = 2'd1;
  localparam logic [1:0] REG_TURNS      = 2'd2;
  localparam logic [1:0] REG_STEP_DELAY = 2'd3;

  localparam logic        RST_ENABLE     = 1'b0;
  localparam logic [8:0]  RST_DEGREES    = 9'd180;
  localparam logic [4:0]  RST_TURNS      = 5'd5;
  localparam logic [15:0] RST_STEP_DELAY = 16'd500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_ramp;
    logic mul_steps;
    logic div_start;
    logic do_step;
    logic do_start;
    logic do_preload;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       busy;
    logic       step_due;
    logic       in_ramp;
    logic       sched_due;
  } dp_stat_t;

  // Seconds between scheduled turns for a given number of turns per day.
  function automatic logic [16:0] win_for_tpd(input logic [4:0] tpd);
    logic [16:0] w;
    case (tpd)
      5'd1:    w = 17'(WINDOW_SECONDS / 1);
      5'd2:    w = 17'(WINDOW_SECONDS / 2);
      5'd3:    w = 17'(WINDOW_SECONDS / 3);
      5'd4:    w = 17'(WINDOW_SECONDS / 4);
      5'd5:    w = 17'(WINDOW_SECONDS / 5);
      5'd6:    w = 17'(WINDOW_SECONDS / 6);
      5'd7:    w = 17'(WINDOW_SECONDS / 7);
      5'd8:    w = 17'(WINDOW_SECONDS / 8);
      5'd9:    w = 17'(WINDOW_SECONDS / 9);
      5'd10:   w = 17'(WINDOW_SECONDS / 10);
      5'd11:   w = 17'(WINDOW_SECONDS / 11);
      5'd12:   w = 17'(WINDOW_SECONDS / 12);
      5'd13:   w = 17'(WINDOW_SECONDS / 13);
      5'd14:   w = 17'(WINDOW_SECONDS / 14);
      5'd15:   w = 17'(WINDOW_SECONDS / 15);
      5'd16:   w = 17'(WINDOW_SECONDS / 16);
      5'd17:   w = 17'(WINDOW_SECONDS / 17);
      5'd18:   w = 17'(WINDOW_SECONDS / 18);
      5'd19:   w = 17'(WINDOW_SECONDS / 19);
      5'd20:   w = 17'(WINDOW_SECONDS / 20);
      5'd21:   w = 17'(WINDOW_SECONDS / 21);
      5'd22:   w = 17'(WINDOW_SECONDS / 22);
      5'd23:   w = 17'(WINDOW_SECONDS / 23);
      5'd24:   w = 17'(WINDOW_SECONDS / 24);
      default: w = WINDOW_SECONDS;
    endcase
    return w;
  endfunction

endpackage

// ===== design/sstc_div.sv =====
// Registered division by a constant through multiplication with a scaled reciprocal.
`timescale 1ns / 1ps

module sstc_div #(
  parameter int DIVIDEND_W = 21,
  parameter int DIVISOR    = 20,
  parameter int QUOTIENT_W = 16
) (
  input  logic                  clk,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic [QUOTIENT_W-1:0] quotient
);

  // The rounded-up reciprocal scaled by this shift gives the exact quotient for any dividend.
  localparam int              SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
  localparam int              RECIP_W = DIVIDEND_W + 1;
  localparam int              PROD_W  = DIVIDEND_W + RECIP_W;
  localparam longint unsigned RECIP   =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [PROD_W-1:0]     prod;
  logic [QUOTIENT_W-1:0] quo_r, quo_nxt;

  assign prod    = PROD_W'(dividend) * PROD_W'(RECIP);
  assign quo_nxt = start ? QUOTIENT_W'(prod >> SHIFT) : quo_r;

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule

// ===== design/sstc_datapath.sv =====
// Datapath: configuration registers, turn state, ramp and step arithmetic, result register.
`timescale 1ns / 1ps

module sstc_datapath import sstc_pkg::*; #(
  parameter int MOTOR_STEPS = 200,
  parameter int ACCEL_STEPS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_now_us,
  input  logic [16:0] in_day_seconds,
  input  logic        in_count_as_turn,
  input  logic [7:0]  in_turns_value,
  output logic        out_step_pulse,
  output logic [15:0] out_extra_delay_us,
  output logic        out_direction,
  output logic        out_driver_on,
  output logic        out_turning,
  output logic        out_turn_done,
  output logic [7:0]  out_completed_count,
  output logic [16:0] out_seconds_to_next
);

  localparam int SPR_W   = $clog2(MOTOR_STEPS + 1);
  localparam int ACC_W   = $clog2(ACCEL_STEPS + 1);
  localparam int RAMP_PW = 16 + ACC_W;
  localparam int STEP_PW = 9 + SPR_W;
  localparam int DIV_W   = (RAMP_PW > STEP_PW) ? RAMP_PW : STEP_PW;

  logic        enable_r, enable_nxt;
  logic [8:0]  deg_r, deg_nxt;
  logic [4:0]  tpd_r, tpd_nxt;
  logic [15:0] delay_r, delay_nxt;

  logic        busy_r, busy_nxt;
  logic        dir_r, dir_nxt;
  logic [7:0]  turns_r, turns_nxt;
  logic [15:0] steps_r, steps_nxt;
  logic [15:0] ramp_r, ramp_nxt;
  logic [31:0] last_r, last_nxt;
  logic        test_r, test_nxt;

  logic [1:0]  act_r, act_nxt;
  logic [31:0] now_r, now_nxt;
  logic [16:0] day_r, day_nxt;
  logic        counted_r, counted_nxt;
  logic [7:0]  tval_r, tval_nxt;

  logic        res_pulse_r, res_pulse_nxt;
  logic [15:0] res_extra_r, res_extra_nxt;
  logic        res_done_r, res_done_nxt;

  logic [DIV_W-1:0] mul_r, mul_nxt;

  logic        o_pulse_r, o_pulse_nxt;
  logic [15:0] o_extra_r, o_extra_nxt;
  logic        o_dir_r, o_dir_nxt;
  logic        o_busy_r, o_busy_nxt;
  logic        o_done_r, o_done_nxt;
  logic [7:0]  o_count_r, o_count_nxt;
  logic [16:0] o_wait_r, o_wait_nxt;

  logic               cfg_wr;
  logic [8:0]         wr_deg;
  logic [4:0]         wr_tpd;
  logic [15:0]        phase;
  logic [ACC_W-1:0]   acc_left;
  logic [RAMP_PW-1:0] ramp_prod;
  logic [STEP_PW-1:0] step_prod;
  logic [4:0]         next_idx;
  logic [21:0]        nt_prod;
  logic [16:0]        nt;
  logic               sched_open;
  logic [31:0]        elapsed;
  logic [15:0]        steps_dec;
  logic [15:0]        start_steps;
  logic               start_counted;
  logic [15:0]        quot_ramp;
  logic [15:0]        quot_steps;

  assign cfg_wr = psel & penable & pwrite;
  assign wr_deg = (pwdata[8:0] > DEG_FULL) ? DEG_FULL : pwdata[8:0];
  assign wr_tpd = (pwdata[4:0] < TPD_MIN) ? TPD_MIN :
                  (pwdata[4:0] > TPD_MAX) ? TPD_MAX : pwdata[4:0];

  assign phase     = (ramp_r < steps_r) ? ramp_r : steps_r;
  assign acc_left  = ACC_W'(ACCEL_STEPS) - phase[ACC_W-1:0];
  assign ramp_prod = RAMP_PW'(delay_r) * RAMP_PW'(acc_left);
  assign step_prod = STEP_PW'(deg_r) * STEP_PW'(MOTOR_STEPS);

  assign next_idx   = turns_r[4:0] + 5'd1;
  assign nt_prod    = 22'(next_idx) * 22'(win_for_tpd(tpd_r));
  assign nt         = nt_prod[16:0];
  assign sched_open = enable_r && (turns_r < {3'b000, tpd_r});
  assign elapsed    = now_r - last_r;
  assign steps_dec  = steps_r - 16'd1;

  assign start_steps   = quot_steps;
  assign start_counted = (act_r == ACT_MANUAL) ? counted_r : 1'b1;

  sstc_div #(
    .DIVIDEND_W(RAMP_PW),
    .DIVISOR   (ACCEL_STEPS),
    .QUOTIENT_W(16)
  ) u_div_ramp (
    .clk     (clk),
    .start   (cmd.div_start),
    .dividend(mul_r[RAMP_PW-1:0]),
    .quotient(quot_ramp)
  );

  sstc_div #(
    .DIVIDEND_W(STEP_PW),
    .DIVISOR   (int'(DEG_FULL)),
    .QUOTIENT_W(16)
  ) u_div_steps (
    .clk     (clk),
    .start   (cmd.div_start),
    .dividend(mul_r[STEP_PW-1:0]),
    .quotient(quot_steps)
  );

  always_comb begin
    stat.action    = act_r;
    stat.busy      = busy_r;
    stat.step_due  = elapsed >= {16'd0, delay_r};
    stat.in_ramp   = phase < 16'(ACCEL_STEPS);
    stat.sched_due = sched_open && (day_r >= nt);
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:     prdata = {31'd0, enable_r};
      REG_DEGREES:    prdata = {23'd0, deg_r};
      REG_TURNS:      prdata = {27'd0, tpd_r};
      REG_STEP_DELAY: prdata = {16'd0, delay_r};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    enable_nxt    = enable_r;
    deg_nxt       = deg_r;
    tpd_nxt       = tpd_r;
    delay_nxt     = delay_r;
    busy_nxt      = busy_r;
    dir_nxt       = dir_r;
    turns_nxt     = turns_r;
    steps_nxt     = steps_r;
    ramp_nxt      = ramp_r;
    last_nxt      = last_r;
    test_nxt      = test_r;
    act_nxt       = act_r;
    now_nxt       = now_r;
    day_nxt       = day_r;
    counted_nxt   = counted_r;
    tval_nxt      = tval_r;
    res_pulse_nxt = res_pulse_r;
    res_extra_nxt = res_extra_r;
    res_done_nxt  = res_done_r;
    mul_nxt       = mul_r;
    o_pulse_nxt   = o_pulse_r;
    o_extra_nxt   = o_extra_r;
    o_dir_nxt     = o_dir_r;
    o_busy_nxt    = o_busy_r;
    o_done_nxt    = o_done_r;
    o_count_nxt   = o_count_r;
    o_wait_nxt    = o_wait_r;

    if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENABLE:     enable_nxt = pwdata[0];
        REG_DEGREES:    deg_nxt = wr_deg;
        REG_TURNS:      tpd_nxt = wr_tpd;
        REG_STEP_DELAY: delay_nxt = pwdata[15:0];
        default: ;
      endcase
    end

    if (cmd.capture) begin
      act_nxt       = in_action;
      now_nxt       = in_now_us;
      day_nxt       = in_day_seconds;
      counted_nxt   = in_count_as_turn;
      tval_nxt      = in_turns_value;
      res_pulse_nxt = 1'b0;
      res_extra_nxt = '0;
      res_done_nxt  = 1'b0;
    end

    if (cmd.mul_ramp) begin
      mul_nxt = DIV_W'(ramp_prod);
    end
    if (cmd.mul_steps) begin
      mul_nxt = DIV_W'(step_prod);
    end

    if (cmd.do_step) begin
      res_pulse_nxt = 1'b1;
      res_extra_nxt = stat.in_ramp ? quot_ramp : 16'd0;
      last_nxt      = now_r;
      steps_nxt     = steps_dec;
      ramp_nxt      = ramp_r + 16'd1;
      if (steps_dec == 16'd0) begin
        busy_nxt     = 1'b0;
        dir_nxt      = ~dir_r;
        test_nxt     = 1'b0;
        res_done_nxt = 1'b1;
        if (!test_r) begin
          turns_nxt = turns_r + 8'd1;
        end
      end
    end

    if (cmd.do_start) begin
      steps_nxt = start_steps;
      ramp_nxt  = '0;
      last_nxt  = now_r;
      if (start_steps == 16'd0) begin
        busy_nxt     = 1'b0;
        dir_nxt      = ~dir_r;
        test_nxt     = 1'b0;
        res_done_nxt = 1'b1;
        if (start_counted) begin
          turns_nxt = turns_r + 8'd1;
        end
      end else begin
        busy_nxt = 1'b1;
        test_nxt = ~start_counted;
      end
    end

    if (cmd.do_preload) begin
      turns_nxt = tval_r;
    end

    if (cmd.load_out) begin
      o_pulse_nxt = res_pulse_r;
      o_extra_nxt = res_extra_r;
      o_dir_nxt   = dir_r;
      o_busy_nxt  = busy_r;
      o_done_nxt  = res_done_r;
      o_count_nxt = turns_r;
      o_wait_nxt  = (sched_open && (day_r < nt)) ? (nt - day_r) : 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= RST_ENABLE;
      deg_r    <= RST_DEGREES;
      tpd_r    <= RST_TURNS;
      delay_r  <= RST_STEP_DELAY;
      busy_r   <= 1'b0;
      dir_r    <= 1'b0;
      turns_r  <= '0;
      steps_r  <= '0;
      ramp_r   <= '0;
      last_r   <= '0;
      test_r   <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
      deg_r    <= deg_nxt;
      tpd_r    <= tpd_nxt;
      delay_r  <= delay_nxt;
      busy_r   <= busy_nxt;
      dir_r    <= dir_nxt;
      turns_r  <= turns_nxt;
      steps_r  <= steps_nxt;
      ramp_r   <= ramp_nxt;
      last_r   <= last_nxt;
      test_r   <= test_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    now_r       <= now_nxt;
    day_r       <= day_nxt;
    counted_r   <= counted_nxt;
    tval_r      <= tval_nxt;
    res_pulse_r <= res_pulse_nxt;
    res_extra_r <= res_extra_nxt;
    res_done_r  <= res_done_nxt;
    mul_r       <= mul_nxt;
    o_pulse_r   <= o_pulse_nxt;
    o_extra_r   <= o_extra_nxt;
    o_dir_r     <= o_dir_nxt;
    o_busy_r    <= o_busy_nxt;
    o_done_r    <= o_done_nxt;
    o_count_r   <= o_count_nxt;
    o_wait_r    <= o_wait_nxt;
  end

  assign out_step_pulse      = o_pulse_r;
  assign out_extra_delay_us  = o_extra_r;
  assign out_direction       = o_dir_r;
  assign out_driver_on       = o_busy_r;
  assign out_turning         = o_busy_r;
  assign out_turn_done       = o_done_r;
  assign out_completed_count = o_count_r;
  assign out_seconds_to_next = o_wait_r;

endmodule

// ===== design/sstc_ctrl.sv =====
// Controller state machine that sequences each item through the datapath.
`timescale 1ns / 1ps

module sstc_ctrl import sstc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   kind_step_r, kind_step_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_step_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_step_r <= kind_step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_step_nxt = kind_step_r;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_OUT;
        case (stat.action)
          ACT_TICK: begin
            if (stat.busy) begin
              if (stat.step_due) begin
                if (stat.in_ramp) begin
                  cmd.mul_ramp  = 1'b1;
                  kind_step_nxt = 1'b1;
                  state_nxt     = ST_MUL;
                end else begin
                  cmd.do_step = 1'b1;
                end
              end
            end else if (stat.sched_due) begin
              cmd.mul_steps = 1'b1;
              kind_step_nxt = 1'b0;
              state_nxt     = ST_MUL;
            end
          end
          ACT_MANUAL: begin
            if (!stat.busy) begin
              cmd.mul_steps = 1'b1;
              kind_step_nxt = 1'b0;
              state_nxt     = ST_MUL;
            end
          end
          ACT_PRELOAD: begin
            cmd.do_preload = 1'b1;
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.do_step  = kind_step_r;
        cmd.do_start = ~kind_step_r;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/scheduled_stepper_turn_controller.sv =====
// Top level of the scheduled stepper turn controller.
`timescale 1ns / 1ps
//
// Each input item (tick, manual turn request or count preload) yields exactly one result
// item. Input items enter on in_valid while in_stall is low; results leave on out_valid
// and are held unchanged while out_stall is high. Configuration registers are written
// through the APB-style port at byte addresses 0, 4, 8 and 12, and pready is always high.
// An item that issues no ramp step and starts no turn goes from evaluation straight to
// the output register. An item that issues a ramp step or starts a turn forms a product,
// then divides it by a constant through a registered reciprocal multiplication before
// its result is written. In both cases the next item is accepted once the result has
// been written to the output register.
// One item is in work at a time; a finished result waiting in the output register does
// not keep the block from accepting the next item, but that item's result is not
// written until the waiting one has been taken.
// Reset clears the turn state and restores the register defaults: disabled, 180 degrees
// per turn, 5 turns per day and 500 us between steps.
//

module scheduled_stepper_turn_controller import sstc_pkg::*; #(
  parameter int MOTOR_STEPS = 200,
  parameter int ACCEL_STEPS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_now_us,
  input  logic [16:0] in_day_seconds,
  input  logic        in_count_as_turn,
  input  logic [7:0]  in_turns_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_step_pulse,
  output logic [15:0] out_extra_delay_us,
  output logic        out_direction,
  output logic        out_driver_on,
  output logic        out_turning,
  output logic        out_turn_done,
  output logic [7:0]  out_completed_count,
  output logic [16:0] out_seconds_to_next
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;

  sstc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sstc_datapath #(
    .MOTOR_STEPS(MOTOR_STEPS),
    .ACCEL_STEPS(ACCEL_STEPS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .in_action          (in_action),
    .in_now_us          (in_now_us),
    .in_day_seconds     (in_day_seconds),
    .in_count_as_turn   (in_count_as_turn),
    .in_turns_value     (in_turns_value),
    .out_step_pulse     (out_step_pulse),
    .out_extra_delay_us (out_extra_delay_us),
    .out_direction      (out_direction),
    .out_driver_on      (out_driver_on),
    .out_turning        (out_turning),
    .out_turn_done      (out_turn_done),
    .out_completed_count(out_completed_count),
    .out_seconds_to_next(out_seconds_to_next)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the scheduled stepper turn controller with a built-in turn predictor.

module testbench;
  import sstc_pkg::*;

  localparam int MOTOR_STEPS = 200;
  localparam int ACCEL_STEPS = 20;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        pulse;
    logic [15:0] extra;
    logic        dir;
    logic        drv;
    logic        turning;
    logic        done;
    logic [7:0]  count;
    logic [16:0] secs_next;
  } turn_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [31:0] in_now_us = '0;
  logic [16:0] in_day_seconds = '0;
  logic        in_count_as_turn = 1'b0;
  logic [7:0]  in_turns_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_step_pulse;
  logic [15:0] out_extra_delay_us;
  logic        out_direction;
  logic        out_driver_on;
  logic        out_turning;
  logic        out_turn_done;
  logic [7:0]  out_completed_count;
  logic [16:0] out_seconds_to_next;

  // Predictor copy of the registers and the turn state.
  logic        c_enable  = RST_ENABLE;
  logic [8:0]  c_degrees = RST_DEGREES;
  logic [4:0]  c_turns   = RST_TURNS;
  logic [15:0] c_delay   = RST_STEP_DELAY;
  logic        m_busy = 1'b0;
  logic        m_dir = 1'b0;
  logic [7:0]  m_count = '0;
  logic [15:0] m_steps_left = '0;
  logic [15:0] m_ramp = '0;
  logic [31:0] m_last_us = '0;
  logic        m_test = 1'b0;

  turn_result_t pending_results[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b0;
  logic [31:0] t_now = '0;
  logic [16:0] t_day = '0;

  scheduled_stepper_turn_controller #(
    .MOTOR_STEPS(MOTOR_STEPS),
    .ACCEL_STEPS(ACCEL_STEPS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_now_us(in_now_us),
    .in_day_seconds(in_day_seconds),
    .in_count_as_turn(in_count_as_turn),
    .in_turns_value(in_turns_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_step_pulse(out_step_pulse),
    .out_extra_delay_us(out_extra_delay_us),
    .out_direction(out_direction),
    .out_driver_on(out_driver_on),
    .out_turning(out_turning),
    .out_turn_done(out_turn_done),
    .out_completed_count(out_completed_count),
    .out_seconds_to_next(out_seconds_to_next)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned sched_time();
    return (32'(m_count) + 32'd1) * (32'(WINDOW_SECONDS) / 32'(c_turns));
  endfunction

  function automatic void finish_turn();
    m_busy = 1'b0;
    m_dir = ~m_dir;
    if (!m_test) m_count = m_count + 8'd1;
    m_test = 1'b0;
  endfunction

  function automatic logic start_turn(input logic [31:0] now, input logic counted);
    int unsigned steps;
    steps = (32'(c_degrees) * MOTOR_STEPS) / 32'(DEG_FULL);
    m_steps_left = 16'(steps);
    m_ramp = '0;
    m_test = ~counted;
    m_last_us = now;
    m_busy = 1'b1;
    if (m_steps_left == 16'd0) begin
      finish_turn();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic turn_result_t predict_turn_result(input logic [1:0] action,
      input logic [31:0] now, input logic [16:0] day, input logic counted,
      input logic [7:0] tval);
    turn_result_t r;
    logic [31:0] elapsed;
    int unsigned phase;
    int unsigned due;
    r = '0;
    case (action)
      ACT_TICK: begin
        if (m_busy) begin
          elapsed = now - m_last_us;
          if (elapsed >= 32'(c_delay)) begin
            phase = (m_ramp < m_steps_left) ? 32'(m_ramp) : 32'(m_steps_left);
            if (phase < ACCEL_STEPS)
              r.extra = 16'((32'(c_delay) * (ACCEL_STEPS - phase)) / ACCEL_STEPS);
            r.pulse = 1'b1;
            m_last_us = now;
            m_steps_left = m_steps_left - 16'd1;
            m_ramp = m_ramp + 16'd1;
            if (m_steps_left == 16'd0) begin
              finish_turn();
              r.done = 1'b1;
            end
          end
        end else if (c_enable && m_count < c_turns) begin
          if (32'(day) >= sched_time()) r.done = start_turn(now, 1'b1);
        end
      end
      ACT_MANUAL: begin
        if (!m_busy) r.done = start_turn(now, counted);
      end
      ACT_PRELOAD: begin
        m_count = tval;
      end
      default: begin
      end
    endcase
    if (c_enable && m_count < c_turns) begin
      due = sched_time();
      if (32'(day) < due) r.secs_next = 17'(due - 32'(day));
    end
    r.dir = m_dir;
    r.drv = m_busy;
    r.turning = m_busy;
    r.count = m_count;
    return r;
  endfunction

  function automatic logic [31:0] stored_value(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      REG_ENABLE:  return {31'd0, val[0]};
      REG_DEGREES: return (val[8:0] > DEG_FULL) ? 32'(DEG_FULL) : 32'(val[8:0]);
      REG_TURNS: begin
        if (val[4:0] < TPD_MIN) return 32'(TPD_MIN);
        else if (val[4:0] > TPD_MAX) return 32'(TPD_MAX);
        else return 32'(val[4:0]);
      end
      default:     return 32'(val[15:0]);
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic apb_transfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
      output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    logic [31:0] got;
    logic [31:0] mask;
    want = stored_value(idx, val);
    apb_transfer(1'b1, idx, val, got);
    case (idx)
      REG_ENABLE:  begin c_enable = want[0];        mask = 32'h1;    end
      REG_DEGREES: begin c_degrees = want[8:0];     mask = 32'h1FF;  end
      REG_TURNS:   begin c_turns = want[4:0];       mask = 32'h1F;   end
      default:     begin c_delay = want[15:0];      mask = 32'hFFFF; end
    endcase
    apb_transfer(1'b0, idx, 32'd0, got);
    compare_field("register readback", want, got & mask);
  endtask

  task automatic send_item(input logic [1:0] action, input logic [31:0] now,
      input logic [16:0] day, input logic counted, input logic [7:0] tval);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_now_us <= now;
    in_day_seconds <= day;
    in_count_as_turn <= counted;
    in_turns_value <= tval;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_turn_result(action, now, day, counted, tval));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_items(input int count);
    int r;
    logic [1:0] act;
    logic [7:0] tval;
    t_now = $urandom;
    t_day = '0;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) t_now = t_now + 32'(c_delay) + 32'($urandom_range(0, 3));
      else if (r < 88) t_now = t_now + 32'($urandom_range(0, c_delay));
      else t_now = $urandom;
      r = $urandom_range(0, 99);
      if (r < 75)
        t_day = (t_day > 17'd84000) ? 17'($urandom_range(0, 3000))
                                    : t_day + 17'($urandom_range(0, 2399));
      else
        t_day = 17'($urandom_range(0, 86399));
      r = $urandom_range(0, 99);
      if (r < 80) act = ACT_TICK;
      else if (r < 90) act = ACT_MANUAL;
      else if (r < 97) act = ACT_PRELOAD;
      else act = ACT_NONE;
      tval = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 24)) : 8'($urandom);
      send_item(act, t_now, t_day, 1'($urandom), tval);
    end
  endtask

  task automatic test_reset_state();
    send_item(ACT_TICK, 32'd0, 17'd0, 1'b0, 8'd0);
    send_item(ACT_NONE, 32'hFFFF_FFFF, 17'd86399, 1'b1, 8'hFF);
  endtask

  task automatic test_register_access();
    wait_idle();
    set_config(REG_ENABLE, 32'hFFFF_FFFF);
    set_config(REG_DEGREES, 32'd511);
    set_config(REG_DEGREES, 32'd0);
    set_config(REG_TURNS, 32'd0);
    set_config(REG_TURNS, 32'd31);
    set_config(REG_STEP_DELAY, 32'd65535);
    set_config(REG_STEP_DELAY, 32'd1);
    set_config(REG_ENABLE, 32'd0);
  endtask

  task automatic test_manual_turn();
    wait_idle();
    set_config(REG_DEGREES, 32'd9);
    set_config(REG_STEP_DELAY, 32'd10);
    send_item(ACT_MANUAL, 32'd1000, 17'd100, 1'b1, 8'd0);
    send_item(ACT_TICK, 32'd1009, 17'd100, 1'b0, 8'd0);
    send_item(ACT_MANUAL, 32'd1009, 17'd100, 1'b1, 8'd0);
    send_item(ACT_TICK, 32'd1010, 17'd100, 1'b0, 8'd0);
    send_item(ACT_TICK, 32'd1020, 17'd100, 1'b0, 8'd0);
    send_item(ACT_TICK, 32'd1035, 17'd100, 1'b0, 8'd0);
    send_item(ACT_TICK, 32'd1045, 17'd100, 1'b0, 8'd0);
    send_item(ACT_TICK, 32'd1055, 17'd100, 1'b0, 8'd0);
  endtask

  task automatic test_zero_step_turn();
    wait_idle();
    set_config(REG_DEGREES, 32'd0);
    send_item(ACT_MANUAL, 32'd5, 17'd0, 1'b0, 8'd0);
    send_item(ACT_MANUAL, 32'd6, 17'd0, 1'b1, 8'd0);
  endtask

  task automatic test_schedule();
    wait_idle();
    set_config(REG_ENABLE, 32'd1);
    set_config(REG_TURNS, 32'd24);
    send_item(ACT_PRELOAD, 32'd0, 17'd0, 1'b0, 8'd0);
    send_item(ACT_TICK, 32'd10, 17'd3299, 1'b0, 8'd0);
    send_item(ACT_TICK, 32'd20, 17'd3300, 1'b0, 8'd0);
    send_item(ACT_PRELOAD, 32'd30, 17'd3300, 1'b0, 8'd255);
    send_item(ACT_PRELOAD, 32'd40, 17'd3300, 1'b0, 8'd23);
    send_item(ACT_TICK, 32'd50, 17'd86399, 1'b0, 8'd0);
    send_item(ACT_TICK, 32'd60, 17'd86399, 1'b0, 8'd0);
  endtask

  task automatic test_wrap_around();
    wait_idle();
    set_config(REG_ENABLE, 32'd0);
    set_config(REG_DEGREES, 32'd2);
    set_config(REG_STEP_DELAY, 32'd100);
    send_item(ACT_MANUAL, 32'hFFFF_FFC0, 17'd0, 1'b1, 8'd0);
    send_item(ACT_TICK, 32'h0000_0030, 17'd0, 1'b0, 8'd0);
    send_item(ACT_PRELOAD, 32'h0000_0040, 17'd0, 1'b0, 8'd255);
    wait_idle();
    set_config(REG_DEGREES, 32'd0);
    send_item(ACT_MANUAL, 32'h0000_0050, 17'd0, 1'b1, 8'd0);
  endtask

  task automatic test_random_short_turns();
    wait_idle();
    set_config(REG_ENABLE, 32'd1);
    set_config(REG_DEGREES, 32'd18);
    set_config(REG_TURNS, 32'd24);
    set_config(REG_STEP_DELAY, 32'd1);
    idle_on = 1'b1;
    send_random_items(250);
  endtask

  task automatic test_random_long_turns();
    wait_idle();
    set_config(REG_DEGREES, 32'd360);
    set_config(REG_TURNS, 32'd1);
    set_config(REG_STEP_DELAY, 32'd65535);
    idle_on = 1'b0;
    send_random_items(200);
  endtask

  task automatic test_random_disabled();
    wait_idle();
    set_config(REG_ENABLE, 32'd0);
    set_config(REG_DEGREES, 32'd72);
    set_config(REG_TURNS, 32'd5);
    set_config(REG_STEP_DELAY, 32'd500);
    idle_on = 1'b1;
    send_random_items(250);
  endtask

  task automatic test_random_zero_step();
    wait_idle();
    set_config(REG_ENABLE, 32'd1);
    set_config(REG_DEGREES, 32'd1);
    set_config(REG_TURNS, 32'd12);
    set_config(REG_STEP_DELAY, 32'd37);
    send_random_items(150);
  endtask

  task automatic test_steady_stream();
    wait_idle();
    set_config(REG_DEGREES, 32'd45);
    set_config(REG_TURNS, 32'd24);
    set_config(REG_STEP_DELAY, 32'd3);
    idle_on = 1'b0;
    send_random_items(300);
  endtask

  always @(posedge clk) begin : stall_gen
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    turn_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result item with no expectation, expected none, actual count %0d",
                 $time, out_completed_count);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("step_pulse", 32'(exp_r.pulse), 32'(out_step_pulse));
        compare_field("extra_delay_us", 32'(exp_r.extra), 32'(out_extra_delay_us));
        compare_field("direction", 32'(exp_r.dir), 32'(out_direction));
        compare_field("driver_on", 32'(exp_r.drv), 32'(out_driver_on));
        compare_field("turning", 32'(exp_r.turning), 32'(out_turning));
        compare_field("turn_done", 32'(exp_r.done), 32'(out_turn_done));
        compare_field("completed_count", 32'(exp_r.count), 32'(out_completed_count));
        compare_field("seconds_to_next", 32'(exp_r.secs_next), 32'(out_seconds_to_next));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    idle_on = 1'b1;
    test_reset_state();
    test_register_access();
    test_manual_turn();
    test_zero_step_turn();
    test_schedule();
    test_wrap_around();
    test_random_short_turns();
    test_random_long_turns();
    test_random_disabled();
    test_random_zero_step();
    test_steady_stream();
    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
